// ===== hdl/ppm_pkg.sv =====
// Shared types and constants for the PPM frame decoder.
// Used by the interfaces, the front end, the command queue, the drain unit and the top level.
package ppm_pkg;

  localparam int unsigned TIME_W = 16;
  localparam int unsigned CNT_W  = 5;   // holds a channel count of up to 31
  localparam int unsigned IDX_W  = 4;   // channel position within a frame
  localparam int unsigned ADDR_W = 5;   // register byte address
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_MIN_START_GAP    = 3'd0;
  localparam logic [2:0] REG_MAX_PULSE_WIDTH  = 3'd1;
  localparam logic [2:0] REG_MIN_CHANNEL_TIME = 3'd2;
  localparam logic [2:0] REG_MAX_CHANNEL_TIME = 3'd3;
  localparam logic [2:0] REG_LOCK_FRAMES      = 3'd4;
  localparam logic [2:0] REG_MIN_CHANNELS     = 3'd5;

  localparam logic [15:0] RST_MIN_START_GAP    = 16'd2500;
  localparam logic [15:0] RST_MAX_PULSE_WIDTH  = 16'd500;
  localparam logic [15:0] RST_MIN_CHANNEL_TIME = 16'd800;
  localparam logic [15:0] RST_MAX_CHANNEL_TIME = 16'd2200;
  localparam logic [3:0]  RST_LOCK_FRAMES      = 4'd3;
  localparam logic [3:0]  RST_MIN_CHANNELS     = 4'd4;

  typedef struct packed {
    logic [TIME_W-1:0] min_start_gap;
    logic [TIME_W-1:0] max_pulse_width;
    logic [TIME_W-1:0] min_channel_time;
    logic [TIME_W-1:0] max_channel_time;
    logic [3:0]        lock_frames;
    logic [3:0]        min_channels;
  } cfg_t;

  // One published frame waiting for the drain unit
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] locked;
  } cmd_t;

  // Channel store write from the front end
  typedef struct packed {
    logic              en;
    logic              bank;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] data;
  } wr_t;

  // Drain unit hands a store bank back to the front end
  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

  typedef enum logic [3:0] {
    PH_UNSYNCED = 4'b0001,
    PH_ARMED    = 4'b0010,
    PH_INACTIVE = 4'b0100,
    PH_ACTIVE   = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    DR_IDLE = 3'b001,
    DR_READ = 3'b010,
    DR_EMIT = 3'b100
  } drain_state_t;

endpackage

// ===== hdl/ppm_if.sv =====
// Valid/ready channel interfaces for capture events and channel results.
// Depends on ppm_pkg for field widths.
interface ppm_in_if;
  logic                       valid;
  logic                       ready;
  logic [ppm_pkg::TIME_W-1:0] capture_time;
  logic                       missed_edge;

  modport source (output valid, output capture_time, output missed_edge, input ready);
  modport sink (input valid, input capture_time, input missed_edge, output ready);
endinterface

interface ppm_out_if;
  logic                       valid;
  logic                       ready;
  logic [ppm_pkg::IDX_W-1:0]  channel_index;
  logic [ppm_pkg::TIME_W-1:0] channel_value;
  logic                       last_of_frame;
  logic [3:0]                 locked_channels;

  modport source (output valid, output channel_index, output channel_value,
                  output last_of_frame, output locked_channels, input ready);
  modport sink (input valid, input channel_index, input channel_value,
                input last_of_frame, input locked_channels, output ready);
endinterface

// ===== hdl/ppm_front.sv =====
// Front end: accepts capture events, runs the phase machine and the count lock logic.
// Writes channel intervals into the drain unit's store; depends on ppm_pkg and ppm_if.
module ppm_front #(
  parameter int unsigned MAX_CHANNELS = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ppm_pkg::cfg_t   cfg,
  ppm_in_if.sink          in_ch,
  output ppm_pkg::wr_t    wr,
  output logic            push,
  output ppm_pkg::cmd_t   push_cmd,
  input  ppm_pkg::rel_t   rel
);

  localparam logic [ppm_pkg::CNT_W-1:0] MAX_CNT = ppm_pkg::CNT_W'(MAX_CHANNELS);

  logic [ppm_pkg::TIME_W-1:0] prev_edge_r, prev_edge_nxt;
  logic [ppm_pkg::TIME_W-1:0] prev_mark_r, prev_mark_nxt;
  logic [ppm_pkg::CNT_W-1:0]  fcc_r, fcc_nxt;
  logic [ppm_pkg::CNT_W-1:0]  acc_cnt_r, acc_cnt_nxt;
  logic [ppm_pkg::CNT_W-1:0]  cand_r, cand_nxt;
  logic [3:0]                 hold_r, hold_nxt;
  ppm_pkg::phase_t            phase_r, phase_nxt;
  logic                       bank_r, bank_nxt;
  logic [1:0]                 busy_r, busy_nxt;

  logic                       take;
  logic [ppm_pkg::TIME_W-1:0] width;
  logic [ppm_pkg::TIME_W-1:0] interval;

  assign in_ch.ready = !busy_r[bank_r];
  assign take        = in_ch.valid && in_ch.ready;
  assign width       = in_ch.capture_time - prev_edge_r;
  assign interval    = in_ch.capture_time - prev_mark_r;

  always_comb begin
    prev_edge_nxt = prev_edge_r;
    prev_mark_nxt = prev_mark_r;
    fcc_nxt       = fcc_r;
    acc_cnt_nxt   = acc_cnt_r;
    cand_nxt      = cand_r;
    hold_nxt      = hold_r;
    phase_nxt     = phase_r;
    bank_nxt      = bank_r;
    busy_nxt      = busy_r;
    push          = 1'b0;
    push_cmd      = '{bank: bank_r, count: fcc_r, locked: acc_cnt_r};
    wr            = '{en: 1'b0, bank: bank_r, idx: fcc_r[ppm_pkg::IDX_W-1:0],
                      data: interval};

    if (rel.en) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (take) begin
      if (in_ch.missed_edge) begin
        phase_nxt   = ppm_pkg::PH_UNSYNCED;
        acc_cnt_nxt = '0;
      end else begin
        prev_edge_nxt = in_ch.capture_time;
        if (width >= cfg.min_start_gap) begin
          if (fcc_r != acc_cnt_r) begin
            priority if (cand_r != fcc_r) begin
              cand_nxt = fcc_r;
              hold_nxt = cfg.lock_frames;
            end else if (hold_r != 4'd0) begin
              hold_nxt = hold_r - 4'd1;
            end else begin
              acc_cnt_nxt = cand_r;
              cand_nxt    = '0;
            end
          end else if (fcc_r > {1'b0, cfg.min_channels}) begin
            // hand the filled bank to the drain unit and switch banks
            push             = 1'b1;
            busy_nxt[bank_r] = 1'b1;
            bank_nxt         = !bank_r;
          end
          fcc_nxt   = '0;
          phase_nxt = ppm_pkg::PH_ARMED;
        end else begin
          unique case (phase_r)
            ppm_pkg::PH_ARMED: begin
              if (width > cfg.max_pulse_width) begin
                phase_nxt   = ppm_pkg::PH_UNSYNCED;
                acc_cnt_nxt = '0;
              end else begin
                prev_mark_nxt = in_ch.capture_time;
                phase_nxt     = ppm_pkg::PH_INACTIVE;
              end
            end
            ppm_pkg::PH_INACTIVE: begin
              phase_nxt = ppm_pkg::PH_ACTIVE;
            end
            ppm_pkg::PH_ACTIVE: begin
              if (width > cfg.max_pulse_width) begin
                phase_nxt   = ppm_pkg::PH_UNSYNCED;
                acc_cnt_nxt = '0;
              end else begin
                prev_mark_nxt = in_ch.capture_time;
                if (interval < cfg.min_channel_time || interval > cfg.max_channel_time) begin
                  phase_nxt   = ppm_pkg::PH_UNSYNCED;
                  acc_cnt_nxt = '0;
                end else begin
                  // drop the interval once the store is full
                  if (fcc_r < MAX_CNT) begin
                    wr.en   = 1'b1;
                    fcc_nxt = fcc_r + 1'b1;
                  end
                  phase_nxt = ppm_pkg::PH_INACTIVE;
                end
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_edge_r <= '0;
      prev_mark_r <= '0;
      fcc_r       <= '0;
      acc_cnt_r   <= '0;
      cand_r      <= '0;
      hold_r      <= '0;
      phase_r     <= ppm_pkg::PH_UNSYNCED;
      bank_r      <= 1'b0;
      busy_r      <= '0;
    end else begin
      prev_edge_r <= prev_edge_nxt;
      prev_mark_r <= prev_mark_nxt;
      fcc_r       <= fcc_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      cand_r      <= cand_nxt;
      hold_r      <= hold_nxt;
      phase_r     <= phase_nxt;
      bank_r      <= bank_nxt;
      busy_r      <= busy_nxt;
    end
  end

endmodule

// ===== hdl/ppm_cmd_fifo.sv =====
// Two-entry queue of published frames between the front end and the drain unit.
// Depends on ppm_pkg for the command type.
module ppm_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ppm_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          avail,
  output ppm_pkg::cmd_t head
);

  ppm_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    fill_r, fill_nxt;
  logic          do_pop;

  assign avail  = fill_r != 2'd0;
  assign head   = slot_r[rd_ptr_r];
  assign do_pop = pop && avail;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== hdl/ppm_drain.sv =====
// Drain unit: holds the two-bank channel store and plays a published frame out as results.
// Depends on ppm_pkg and ppm_if.
module ppm_drain #(
  parameter int unsigned MAX_CHANNELS = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ppm_pkg::wr_t  wr,
  input  logic          cmd_avail,
  input  ppm_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output ppm_pkg::rel_t rel,
  ppm_out_if.source     out_ch
);

  localparam int unsigned DEPTH = 2 * MAX_CHANNELS;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [ppm_pkg::TIME_W-1:0] store_r [DEPTH];
  logic [ppm_pkg::TIME_W-1:0] rdata_r;

  ppm_pkg::drain_state_t      state_r, state_nxt;
  ppm_pkg::cmd_t              cmd_r, cmd_nxt;
  logic [ppm_pkg::CNT_W-1:0]  idx_r, idx_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [ppm_pkg::IDX_W-1:0]  out_index_r, out_index_nxt;
  logic [ppm_pkg::TIME_W-1:0] out_value_r, out_value_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [3:0]                 out_locked_r, out_locked_nxt;

  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          load;
  logic          last;

  assign wr_addr = AW'(wr.idx) + (wr.bank ? AW'(MAX_CHANNELS) : AW'(0));
  assign rd_addr = AW'(idx_r) + (cmd_r.bank ? AW'(MAX_CHANNELS) : AW'(0));

  always_ff @(posedge clk) begin
    if (wr.en) begin
      store_r[wr_addr] <= wr.data;
    end
    if (state_r == ppm_pkg::DR_READ) begin
      rdata_r <= store_r[rd_addr];
    end
  end

  assign load = !out_valid_r || out_ch.ready;
  assign last = (idx_r + 1'b1) == cmd_r.count;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    cmd_pop        = 1'b0;
    rel            = '{en: 1'b0, bank: cmd_r.bank};
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_index_nxt  = out_index_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_locked_nxt = out_locked_r;

    unique case (state_r)
      ppm_pkg::DR_IDLE: begin
        if (cmd_avail) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd;
          idx_nxt   = '0;
          state_nxt = ppm_pkg::DR_READ;
        end
      end
      ppm_pkg::DR_READ: begin
        state_nxt = ppm_pkg::DR_EMIT;
      end
      ppm_pkg::DR_EMIT: begin
        // hold the read value until the output register frees up
        if (load) begin
          out_valid_nxt  = 1'b1;
          out_index_nxt  = idx_r[ppm_pkg::IDX_W-1:0];
          out_value_nxt  = rdata_r;
          out_last_nxt   = last;
          out_locked_nxt = cmd_r.locked[3:0];
          if (last) begin
            rel.en    = 1'b1;
            state_nxt = ppm_pkg::DR_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ppm_pkg::DR_READ;
          end
        end
      end
      default: begin
        state_nxt = ppm_pkg::DR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    out_index_r  <= out_index_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_locked_r <= out_locked_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppm_pkg::DR_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.channel_index   = out_index_r;
  assign out_ch.channel_value   = out_value_r;
  assign out_ch.last_of_frame   = out_last_r;
  assign out_ch.locked_channels = out_locked_r;

endmodule

// ===== hdl/ppm_frame_decoder.sv =====
// PPM frame decoder top level: configuration registers, front end, frame queue, drain unit.
// Flow: a capture event is taken while ready is high; a frame end that publishes queues the
// frame, then its channel values come out one at a time, each by a store read and an output load.
// Throughput: one event per cycle while the store bank being filled is free; the front end
// stalls only when both banks hold frames not yet played out. Synchronous active-low reset
// clears all control state and loads the register defaults; the channel store is not cleared.
module ppm_frame_decoder #(
  parameter int unsigned MAX_CHANNELS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ppm_in_if.sink                      in_ch,
  ppm_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppm_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppm_pkg::DATA_W-1:0]  pwdata,
  output logic [ppm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  ppm_pkg::cfg_t cfg_r, cfg_nxt;
  logic          cfg_we;
  logic [2:0]    reg_sel;

  ppm_pkg::wr_t  wr;
  logic          push;
  ppm_pkg::cmd_t push_cmd;
  logic          cmd_pop;
  logic          cmd_avail;
  ppm_pkg::cmd_t head;
  ppm_pkg::rel_t rel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_sel)
        ppm_pkg::REG_MIN_START_GAP:    cfg_nxt.min_start_gap    = pwdata[15:0];
        ppm_pkg::REG_MAX_PULSE_WIDTH:  cfg_nxt.max_pulse_width  = pwdata[15:0];
        ppm_pkg::REG_MIN_CHANNEL_TIME: cfg_nxt.min_channel_time = pwdata[15:0];
        ppm_pkg::REG_MAX_CHANNEL_TIME: cfg_nxt.max_channel_time = pwdata[15:0];
        ppm_pkg::REG_LOCK_FRAMES:      cfg_nxt.lock_frames      = pwdata[3:0];
        ppm_pkg::REG_MIN_CHANNELS:     cfg_nxt.min_channels     = pwdata[3:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ppm_pkg::REG_MIN_START_GAP:    prdata = {16'd0, cfg_r.min_start_gap};
      ppm_pkg::REG_MAX_PULSE_WIDTH:  prdata = {16'd0, cfg_r.max_pulse_width};
      ppm_pkg::REG_MIN_CHANNEL_TIME: prdata = {16'd0, cfg_r.min_channel_time};
      ppm_pkg::REG_MAX_CHANNEL_TIME: prdata = {16'd0, cfg_r.max_channel_time};
      ppm_pkg::REG_LOCK_FRAMES:      prdata = {28'd0, cfg_r.lock_frames};
      ppm_pkg::REG_MIN_CHANNELS:     prdata = {28'd0, cfg_r.min_channels};
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_start_gap    <= ppm_pkg::RST_MIN_START_GAP;
      cfg_r.max_pulse_width  <= ppm_pkg::RST_MAX_PULSE_WIDTH;
      cfg_r.min_channel_time <= ppm_pkg::RST_MIN_CHANNEL_TIME;
      cfg_r.max_channel_time <= ppm_pkg::RST_MAX_CHANNEL_TIME;
      cfg_r.lock_frames      <= ppm_pkg::RST_LOCK_FRAMES;
      cfg_r.min_channels     <= ppm_pkg::RST_MIN_CHANNELS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ppm_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_ch    (in_ch),
    .wr       (wr),
    .push     (push),
    .push_cmd (push_cmd),
    .rel      (rel)
  );

  ppm_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .avail    (cmd_avail),
    .head     (head)
  );

  ppm_drain #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .cmd_avail (cmd_avail),
    .cmd       (head),
    .cmd_pop   (cmd_pop),
    .rel       (rel),
    .out_ch    (out_ch)
  );

endmodule

// ===== sim/ppm_frame_decoder_checker.sv =====
// Scoreboard for the PPM frame decoder: tracks register writes, decodes every accepted
// capture event in step with the block and compares each channel value it publishes.
// Depends on ppm_pkg and the channel interfaces in ppm_if.sv.
module ppm_frame_decoder_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  ppm_in_if                           in_mon,
  ppm_out_if                          out_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ppm_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppm_pkg::DATA_W-1:0]  pwdata,
  output int                          errors,
  output int                          pending,
  output int                          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 12;

  typedef struct packed {
    logic [ppm_pkg::IDX_W-1:0]  index;
    logic [ppm_pkg::TIME_W-1:0] value;
    logic                       last;
    logic [3:0]                 locked;
  } chan_result_t;

  chan_result_t               values_due[$];
  ppm_pkg::cfg_t              cfg;
  logic [ppm_pkg::TIME_W-1:0] edge_stamp;
  logic [ppm_pkg::TIME_W-1:0] mark_time;
  logic [3:0]                 chan_count;
  logic [3:0]                 locked_cnt;
  logic [3:0]                 cand_cnt;
  logic [3:0]                 hold_cnt;
  ppm_pkg::phase_t            phase;
  logic [ppm_pkg::TIME_W-1:0] chan_store [STORE_DEPTH];

  function automatic void lose_sync();
    phase      = ppm_pkg::PH_UNSYNCED;
    locked_cnt = '0;
  endfunction

  function automatic void decode_edge(input logic [ppm_pkg::TIME_W-1:0] t, input logic lost);
    logic [ppm_pkg::TIME_W-1:0] width;
    logic [ppm_pkg::TIME_W-1:0] interval;
    chan_result_t               r;
    if (lost) begin
      lose_sync();
      return;
    end
    width      = t - edge_stamp;
    edge_stamp = t;
    if (width >= cfg.min_start_gap) begin
      if (chan_count != locked_cnt) begin
        // a new count must repeat through the holdoff before it is taken
        if (cand_cnt != chan_count) begin
          cand_cnt = chan_count;
          hold_cnt = cfg.lock_frames;
        end else if (hold_cnt != 4'd0) begin
          hold_cnt = hold_cnt - 4'd1;
        end else begin
          locked_cnt = cand_cnt;
          cand_cnt   = '0;
        end
      end else if (chan_count > cfg.min_channels) begin
        for (int i = 0; i < int'(chan_count); i++) begin
          r.index  = ppm_pkg::IDX_W'(i);
          r.value  = chan_store[i];
          r.last   = (i + 1 == int'(chan_count));
          r.locked = locked_cnt;
          values_due.push_back(r);
        end
      end
      chan_count = '0;
      phase      = ppm_pkg::PH_ARMED;
      return;
    end
    unique case (phase)
      ppm_pkg::PH_ARMED: begin
        if (width > cfg.max_pulse_width) begin
          lose_sync();
        end else begin
          mark_time = t;
          phase     = ppm_pkg::PH_INACTIVE;
        end
      end
      ppm_pkg::PH_INACTIVE: begin
        phase = ppm_pkg::PH_ACTIVE;
      end
      ppm_pkg::PH_ACTIVE: begin
        if (width > cfg.max_pulse_width) begin
          lose_sync();
        end else begin
          interval  = t - mark_time;
          mark_time = t;
          if (interval < cfg.min_channel_time || interval > cfg.max_channel_time) begin
            lose_sync();
          end else begin
            // store full: measure but drop
            if (chan_count < STORE_DEPTH) begin
              chan_store[chan_count] = interval;
              chan_count             = chan_count + 4'd1;
            end
            phase = ppm_pkg::PH_INACTIVE;
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    chan_result_t exp_r;
    if (!rst_n) begin
      cfg.min_start_gap    = ppm_pkg::RST_MIN_START_GAP;
      cfg.max_pulse_width  = ppm_pkg::RST_MAX_PULSE_WIDTH;
      cfg.min_channel_time = ppm_pkg::RST_MIN_CHANNEL_TIME;
      cfg.max_channel_time = ppm_pkg::RST_MAX_CHANNEL_TIME;
      cfg.lock_frames      = ppm_pkg::RST_LOCK_FRAMES;
      cfg.min_channels     = ppm_pkg::RST_MIN_CHANNELS;
      edge_stamp = '0;
      mark_time  = '0;
      chan_count = '0;
      locked_cnt = '0;
      cand_cnt   = '0;
      hold_cnt   = '0;
      phase      = ppm_pkg::PH_UNSYNCED;
      values_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[ppm_pkg::ADDR_W-1:2])
          ppm_pkg::REG_MIN_START_GAP:    cfg.min_start_gap    = pwdata[15:0];
          ppm_pkg::REG_MAX_PULSE_WIDTH:  cfg.max_pulse_width  = pwdata[15:0];
          ppm_pkg::REG_MIN_CHANNEL_TIME: cfg.min_channel_time = pwdata[15:0];
          ppm_pkg::REG_MAX_CHANNEL_TIME: cfg.max_channel_time = pwdata[15:0];
          ppm_pkg::REG_LOCK_FRAMES:      cfg.lock_frames      = pwdata[3:0];
          ppm_pkg::REG_MIN_CHANNELS:     cfg.min_channels     = pwdata[3:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        decode_edge(in_mon.capture_time, in_mon.missed_edge);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (values_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%t: unexpected channel value: index %0d value %0d last %0b locked %0d",
                     $realtime, out_mon.channel_index, out_mon.channel_value,
                     out_mon.last_of_frame, out_mon.locked_channels);
          end
        end else begin
          exp_r = values_due.pop_front();
          checked++;
          if (out_mon.channel_index !== exp_r.index || out_mon.channel_value !== exp_r.value ||
              out_mon.last_of_frame !== exp_r.last ||
              out_mon.locked_channels !== exp_r.locked) begin
            errors++;
            if (errors <= 10) begin
              $display("%t: channel mismatch: expected index %0d value %0d last %0b locked %0d",
                       $realtime, exp_r.index, exp_r.value, exp_r.last, exp_r.locked);
              $display("%t:                   actual   index %0d value %0d last %0b locked %0d",
                       $realtime, out_mon.channel_index, out_mon.channel_value,
                       out_mon.last_of_frame, out_mon.locked_channels);
            end
          end
        end
      end
    end
    pending <= values_due.size();
  end

endmodule

// ===== sim/ppm_frame_decoder_test.sv =====
// Top of the PPM frame decoder testbench: clock, reset, register writes, capture event
// stimulus and random backpressure. Depends on ppm_pkg, ppm_if.sv, the decoder RTL and
// ppm_frame_decoder_checker, which predicts and compares the results.
module ppm_frame_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic                       pready;
  logic [ppm_pkg::ADDR_W-1:0] paddr;
  logic [ppm_pkg::DATA_W-1:0] pwdata;
  logic [ppm_pkg::DATA_W-1:0] prdata;

  int errors;
  int pending;
  int checked;

  int            items_sent;
  int            idle_pct;
  int            stall_pct;
  bit            burst;
  int            hold_req;
  int            hold_seen;
  int            hold_left;
  logic [15:0]   t_now;
  ppm_pkg::cfg_t cur;

  ppm_in_if  in_ch();
  ppm_out_if out_ch();

  ppm_frame_decoder i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ppm_frame_decoder_checker i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  always #2 clk = ~clk;

  // Result side: a hold request blocks the output for a long stretch, else random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_seen     <= hold_req;
      hold_left     <= 0;
      out_ch.ready  <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen     <= hold_req;
      hold_left     <= 600;
      out_ch.ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready  <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_edge(input logic [15:0] t, input logic lost);
    int mode;
    while (!burst && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.capture_time <= t;
    in_ch.missed_edge  <= lost;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    // rotate idle pattern: none, sender idle, receiver stalling, both lightly
    mode      = (items_sent / 40) % 4;
    idle_pct  = (mode == 1) ? 88 : (mode == 3) ? 7 : 0;
    stall_pct = (mode == 2) ? 88 : (mode == 3) ? 7 : 0;
  endtask

  task automatic advance_edge(input int unsigned delta);
    t_now = t_now + 16'(delta);
    send_edge(t_now, 1'b0);
  endtask

  // One frame: start gap, first mark edge, then a space edge and a mark edge per channel
  task automatic send_frame(input int n, input bit noisy);
    int unsigned g;
    int unsigned lim;
    int unsigned iv;
    int unsigned lo;
    int unsigned hi;
    int unsigned w2;
    int          bad_at;
    bad_at = (noisy && $urandom_range(99) < 12) ? int'($urandom_range(n)) : -1;
    lim = 65535 - cur.min_start_gap;
    if (lim > 3000) lim = 3000;
    g = ($urandom_range(7) == 0) ? cur.min_start_gap : cur.min_start_gap + $urandom_range(lim);
    advance_edge(g);
    if (cur.min_start_gap == 0) return;
    lim = cur.max_pulse_width;
    if (lim > cur.min_start_gap - 1) lim = cur.min_start_gap - 1;
    advance_edge($urandom_range(lim));
    for (int c = 0; c < n; c++) begin
      if (c == bad_at) begin
        if ($urandom_range(1) == 1) send_edge(16'($urandom), 1'b1);
        else advance_edge($urandom_range(65535));
      end
      iv = $urandom_range(cur.max_channel_time, cur.min_channel_time);
      // keep the space edge short of a start gap and the mark edge within the pulse limit
      lo = (iv >= cur.min_start_gap) ? iv - cur.min_start_gap + 1 : 0;
      hi = (iv < cur.max_pulse_width) ? iv : cur.max_pulse_width;
      w2 = (lo > hi) ? hi : $urandom_range(hi, lo);
      advance_edge(iv - w2);
      advance_edge(w2);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_settings(input ppm_pkg::cfg_t c);
    write_reg(ppm_pkg::REG_MIN_START_GAP, c.min_start_gap);
    write_reg(ppm_pkg::REG_MAX_PULSE_WIDTH, c.max_pulse_width);
    write_reg(ppm_pkg::REG_MIN_CHANNEL_TIME, c.min_channel_time);
    write_reg(ppm_pkg::REG_MAX_CHANNEL_TIME, c.max_channel_time);
    write_reg(ppm_pkg::REG_LOCK_FRAMES, {12'($urandom), c.lock_frames});
    write_reg(ppm_pkg::REG_MIN_CHANNELS, {12'($urandom), c.min_channels});
    cur = c;
  endtask

  // Hold the input until every predicted value is out, then let the pipeline settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic run_frames(input int items, input int n_lo, input int n_hi, input bit noisy);
    int n;
    int start;
    n     = $urandom_range(n_hi, n_lo);
    start = items_sent;
    while (items_sent - start < items) begin
      if ($urandom_range(99) < 20) n = $urandom_range(n_hi, n_lo);
      send_frame(n, noisy);
    end
  endtask

  initial begin
    int unsigned dir_delta [20];
    bit          dir_lost  [20];
    int          start;
    dir_delta = '{0, 0, 2500, 501, 2499, 65535, 500, 300, 499, 3000,
                  0, 1700, 500, 2000, 201, 3000, 0, 299, 501, 12345};
    dir_lost  = '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0,
                  0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.capture_time = '0;
    in_ch.missed_edge  = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    items_sent         = 0;
    idle_pct           = 0;
    stall_pct          = 0;
    burst              = 1'b0;
    hold_req           = 0;
    t_now              = '0;
    cur = '{ppm_pkg::RST_MIN_START_GAP, ppm_pkg::RST_MAX_PULSE_WIDTH,
            ppm_pkg::RST_MIN_CHANNEL_TIME, ppm_pkg::RST_MAX_CHANNEL_TIME,
            ppm_pkg::RST_LOCK_FRAMES, ppm_pkg::RST_MIN_CHANNELS};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: threshold edges, long pulses, interval limits, lost edge, full-range widths
    for (int k = 0; k < 20; k++) begin
      if (dir_lost[k]) send_edge(16'hFFFF, 1'b1);
      else advance_edge(dir_delta[k]);
    end
    wait_drained();

    // Default timing; lock a 5-channel count, then block the output while frames keep coming
    load_settings('{16'd2500, 16'd500, 16'd800, 16'd2200, 4'd3, 4'd4});
    for (int k = 0; k < 6; k++) send_frame(5, 1'b0);
    hold_req <= hold_req + 1;
    burst = 1'b1;
    for (int k = 0; k < 4; k++) send_frame(5, 1'b0);
    burst = 1'b0;
    wait_drained();
    run_frames(30, 0, 14, 1'b1);
    wait_drained();

    // Widest limits: only a full-range width is a start gap, no holdoff, any nonzero count publishes
    load_settings('{16'd65535, 16'd65535, 16'd0, 16'd65535, 4'd0, 4'd0});
    run_frames(30, 0, 6, 1'b1);
    wait_drained();

    // Every edge is a start gap
    load_settings('{16'd0, 16'd0, 16'd65535, 16'd0, 4'd15, 4'd12});
    run_frames(12, 0, 3, 1'b1);
    wait_drained();

    // Zero pulse width, single legal interval, longest holdoff
    load_settings('{16'd3000, 16'd0, 16'd1000, 16'd1000, 4'd15, 4'd0});
    run_frames(88, 1, 1, 1'b0);
    wait_drained();

    // Mid settings with short holdoff; go on until enough values have come out
    load_settings('{16'd2000, 16'd400, 16'd700, 16'd1800, 4'd1, 4'd2});
    start = items_sent;
    while ((items_sent - start < 30 || checked + pending < 60) && items_sent < 1500) begin
      send_frame($urandom_range(14, 2), 1'b1);
    end
    wait_drained();

    $display("Summary: %0d capture events sent, %0d channel values compared,", items_sent,
             checked);
    $display("Summary: five register settings, four idle patterns, one long output hold.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
